// ===== sv/evse_psc_pkg.sv =====
`default_nettype none

package evse_psc_pkg;

    localparam int PORT_COUNT      = 8;
    localparam int RELAYS_PER_PORT = 2;
    localparam int PWM_FULL_SCALE  = 1000;

    localparam int AMPS_CODES = 128;

    localparam logic [1:0] MODE_EVAL   = 2'd0;
    localparam logic [1:0] MODE_TICK   = 2'd1;
    localparam logic [1:0] MODE_UPDATE = 2'd2;

    localparam logic [2:0] ST_UNDEF  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_PAUSED = 3'd7;

    localparam logic [7:0] RELAY_PULSE_RESET = 8'd2;

    // wait, charge, fan
    localparam logic [7:0] POWER_MASK = 8'b0011_1000;
    // charge, fan, paused
    localparam logic [7:0] RELAY_MASK = 8'b1011_0000;

    localparam logic [2:0] TRANS_NEXT [0:7][0:7] = '{
        '{3'd0, 3'd1, 3'd0, 3'd0, 3'd0, 3'd0, 3'd1, 3'd0},
        '{3'd1, 3'd1, 3'd2, 3'd0, 3'd0, 3'd0, 3'd1, 3'd1},
        '{3'd0, 3'd1, 3'd3, 3'd3, 3'd0, 3'd0, 3'd1, 3'd1},
        '{3'd0, 3'd1, 3'd3, 3'd3, 3'd4, 3'd5, 3'd1, 3'd1},
        '{3'd0, 3'd0, 3'd0, 3'd3, 3'd4, 3'd5, 3'd1, 3'd7},
        '{3'd0, 3'd0, 3'd0, 3'd3, 3'd4, 3'd5, 3'd1, 3'd7},
        '{3'd0, 3'd1, 3'd2, 3'd0, 3'd0, 3'd0, 3'd1, 3'd1},
        '{3'd0, 3'd1, 3'd2, 3'd0, 3'd0, 3'd0, 3'd1, 3'd1}
    };

    localparam logic [11:0] TRANS_AGE [0:7][0:7] = '{
        '{12'd0, 12'd100, 12'd0,   12'd0,   12'd0,   12'd0,   12'd10, 12'd0},
        '{12'd0, 12'd0,   12'd100, 12'd0,   12'd0,   12'd0,   12'd0,  12'd0},
        '{12'd0, 12'd0,   12'd100, 12'd0,   12'd0,   12'd0,   12'd0,  12'd0},
        '{12'd0, 12'd0,   12'd0,   12'd0,   12'd100, 12'd100, 12'd0,  12'd0},
        '{12'd0, 12'd0,   12'd0,   12'd0,   12'd0,   12'd0,   12'd10, 12'd0},
        '{12'd0, 12'd0,   12'd0,   12'd0,   12'd0,   12'd0,   12'd10, 12'd0},
        '{12'd0, 12'd0,   12'd10,  12'd0,   12'd0,   12'd0,   12'd0,  12'd0},
        '{12'd0, 12'd0,   12'd10,  12'd0,   12'd0,   12'd0,   12'd10, 12'd2500}
    };

    typedef logic [9:0] pwm_tab_t [AMPS_CODES];

    function automatic pwm_tab_t build_pwm_tab();
        pwm_tab_t t;
        int       r;
        for (int a = 0; a < AMPS_CODES; a++)
        begin
            if (a < 50)
                r = (a * (PWM_FULL_SCALE / 5) + 6) / 12;
            else
                r = (a * (PWM_FULL_SCALE / 10) + 160 * (PWM_FULL_SCALE / 10) + 12) / 25;
            if (r > PWM_FULL_SCALE)
                r = PWM_FULL_SCALE;
            t[a] = r[9:0];
        end
        return t;
    endfunction

    localparam pwm_tab_t PWM_TAB = build_pwm_tab();
    localparam logic [9:0] PWM_FULL = 10'(PWM_FULL_SCALE);

    typedef struct packed {
        logic [1:0]  mode;
        logic [2:0]  port;
        logic [2:0]  measured_state;
        logic [14:0] state_age;
        logic        paused;
        logic        transition_allowed;
        logic [6:0]  current_amps;
    } in_beat_t;

    typedef struct packed {
        logic [2:0] port_state;
        logic [2:0] previous_state;
        logic       state_changed;
        logic       pwm_write;
        logic [9:0] pwm_value;
        logic       coil_event;
        logic [2:0] coil_port;
        logic       coil_latch;
        logic [1:0] coil_relay;
        logic       coil_energized;
        logic       relay_busy;
    } out_beat_t;

    typedef struct packed {
        logic capture;
        logic lookup;
        logic commit;
    } dp_cmd_t;

endpackage

`default_nettype wire

// ===== sv/evse_psc_ctrl.sv =====
`default_nettype none

module evse_psc_ctrl
    import evse_psc_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_stall,
    output logic         out_valid,
    input  wire logic    out_stall,
    output dp_cmd_t      cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_EXEC
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_LOOK;
                end
            end
            S_LOOK:
            begin
                cmd.lookup = 1'b1;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (slot_free)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

`ifndef SYNTHESIS
    a_commit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!out_valid_reg || !out_stall))
        else $error("result loaded over a pending beat");

    a_accept_then_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (in_stall && cmd.lookup))
        else $error("accepted beat not looked up");
`endif

endmodule

`default_nettype wire

// ===== sv/evse_psc_dp.sv =====
`default_nettype none

module evse_psc_dp
    import evse_psc_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire in_beat_t in_data,
    input  wire dp_cmd_t  cmd,
    input  wire logic     cfg_we,
    input  wire logic [7:0] cfg_wdata,
    output out_beat_t     out_data
);

    // captured beat and lookup stage
    in_beat_t    in_reg;
    logic        port_ok_reg;
    logic [2:0]  cur_reg;
    logic [2:0]  nxt_reg;
    logic [11:0] age_reg;
    logic        rc_reg;
    logic [9:0]  pwm_reg;
    out_beat_t   res_reg;
    out_beat_t   res_next;

    // architectural state
    logic [2:0]  port_states_reg  [PORT_COUNT];
    logic        relay_closed_reg [PORT_COUNT];
    logic [15:0] tick_count_reg;
    logic        seq_active_reg;
    logic [2:0]  seq_port_reg;
    logic [1:0]  seq_relay_reg;
    logic        seq_on_reg;
    logic [15:0] seq_start_reg;
    logic [7:0]  relay_pulse_reg;

    logic [15:0] tick_count_next;
    logic        seq_active_next;
    logic [2:0]  seq_port_next;
    logic [1:0]  seq_relay_next;
    logic        seq_on_next;
    logic [15:0] seq_start_next;
    logic        ps_we;
    logic [2:0]  ps_wdata;
    logic        rc_we;
    logic        rc_wdata;

    logic        port_ok_in;
    logic [2:0]  col;
    logic [2:0]  cur_in;
    logic        move;
    logic        relay_want;
    logic [15:0] tick_inc;
    logic [15:0] elapsed;
    logic [8:0]  need;
    logic [2:0]  relay_inc;

    assign port_ok_in = ({1'b0, in_reg.port} < 4'(PORT_COUNT));
    assign col        = in_reg.paused ? ST_PAUSED : in_reg.measured_state;
    assign cur_in     = port_ok_in ? port_states_reg[in_reg.port] : ST_UNDEF;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            in_reg <= in_data;
        if (cmd.lookup)
        begin
            port_ok_reg <= port_ok_in;
            cur_reg     <= cur_in;
            nxt_reg     <= TRANS_NEXT[cur_in][col];
            age_reg     <= TRANS_AGE[cur_in][col];
            rc_reg      <= port_ok_in ? relay_closed_reg[in_reg.port] : 1'b0;
            pwm_reg     <= PWM_TAB[in_reg.current_amps];
        end
        if (cmd.commit)
            res_reg <= res_next;
    end

    assign move       = ({3'b0, age_reg} <= in_reg.state_age) && (nxt_reg != cur_reg)
                        && in_reg.transition_allowed;
    assign relay_want = RELAY_MASK[nxt_reg];
    assign tick_inc   = tick_count_reg + 16'd1;
    assign elapsed    = tick_inc - seq_start_reg;
    assign need       = {1'b0, relay_pulse_reg} + {8'b0, (seq_relay_reg == 2'd0)};
    assign relay_inc  = {1'b0, seq_relay_reg} + 3'd1;

    always_comb
    begin
        res_next        = '0;
        tick_count_next = tick_count_reg;
        seq_active_next = seq_active_reg;
        seq_port_next   = seq_port_reg;
        seq_relay_next  = seq_relay_reg;
        seq_on_next     = seq_on_reg;
        seq_start_next  = seq_start_reg;
        ps_we           = 1'b0;
        ps_wdata        = nxt_reg;
        rc_we           = 1'b0;
        rc_wdata        = relay_want;
        case (in_reg.mode)
            MODE_EVAL:
            begin
                if (port_ok_reg)
                begin
                    res_next.port_state     = cur_reg;
                    res_next.previous_state = cur_reg;
                    if (move)
                    begin
                        ps_we                  = 1'b1;
                        res_next.port_state    = nxt_reg;
                        res_next.state_changed = 1'b1;
                        res_next.pwm_write     = 1'b1;
                        res_next.pwm_value     = POWER_MASK[nxt_reg] ? pwm_reg : PWM_FULL;
                        if (relay_want != rc_reg)
                        begin
                            rc_we                   = 1'b1;
                            seq_port_next           = in_reg.port;
                            seq_relay_next          = 2'd0;
                            seq_start_next          = tick_count_reg;
                            seq_on_next             = relay_want;
                            seq_active_next         = 1'b1;
                            res_next.coil_event     = 1'b1;
                            res_next.coil_port      = in_reg.port;
                            res_next.coil_latch     = relay_want;
                            res_next.coil_relay     = 2'd0;
                            res_next.coil_energized = 1'b1;
                        end
                    end
                end
            end
            MODE_TICK:
            begin
                tick_count_next = tick_inc;
                if (seq_active_reg && (elapsed >= {7'b0, need}))
                begin
                    seq_relay_next      = relay_inc[1:0];
                    res_next.coil_event = 1'b1;
                    res_next.coil_port  = seq_port_reg;
                    res_next.coil_latch = seq_on_reg;
                    if (relay_inc >= 3'(RELAYS_PER_PORT))
                    begin
                        seq_active_next         = 1'b0;
                        res_next.coil_relay     = seq_relay_reg;
                        res_next.coil_energized = 1'b0;
                    end
                    else
                    begin
                        seq_start_next          = tick_inc;
                        res_next.coil_relay     = relay_inc[1:0];
                        res_next.coil_energized = 1'b1;
                    end
                end
            end
            MODE_UPDATE:
            begin
                if (port_ok_reg)
                begin
                    res_next.port_state     = cur_reg;
                    res_next.previous_state = cur_reg;
                    if (POWER_MASK[cur_reg])
                    begin
                        res_next.pwm_write = 1'b1;
                        res_next.pwm_value = pwm_reg;
                    end
                end
            end
            default:
            begin
                res_next = '0;
            end
        endcase
        res_next.relay_busy = seq_active_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PORT_COUNT; i++)
            begin
                port_states_reg[i]  <= ST_IDLE;
                relay_closed_reg[i] <= 1'b0;
            end
            tick_count_reg  <= '0;
            seq_active_reg  <= 1'b0;
            seq_port_reg    <= '0;
            seq_relay_reg   <= '0;
            seq_on_reg      <= 1'b0;
            seq_start_reg   <= '0;
            relay_pulse_reg <= RELAY_PULSE_RESET;
        end
        else
        begin
            if (cfg_we)
                relay_pulse_reg <= cfg_wdata;
            if (cmd.commit)
            begin
                if (ps_we)
                    port_states_reg[in_reg.port] <= ps_wdata;
                if (rc_we)
                    relay_closed_reg[in_reg.port] <= rc_wdata;
                tick_count_reg <= tick_count_next;
                seq_active_reg <= seq_active_next;
                seq_port_reg   <= seq_port_next;
                seq_relay_reg  <= seq_relay_next;
                seq_on_reg     <= seq_on_next;
                seq_start_reg  <= seq_start_next;
            end
        end
    end

    assign out_data = res_reg;

`ifndef SYNTHESIS
    a_seq_start_on_commit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(seq_active_reg) |-> $past(cmd.commit))
        else $error("coil sequence started outside commit");

    a_move_issues_pwm: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && res_next.state_changed) |-> res_next.pwm_write)
        else $error("state change without pwm beat");
`endif

endmodule

`default_nettype wire

// ===== sv/evse_port_state_controller_core.sv =====
`default_nettype none

// channel  dir  handshake             payload
// in       in   in_valid / in_stall   in_data   (in_beat_t)
// out      out  out_valid / out_stall out_data  (out_beat_t)
// cfg      in   cfg_we                cfg_wdata (relay_pulse_ticks)
//
// every beat passes through three steps: capture, table and pwm lookup, commit
// the commit waits while the output register still holds an untaken beat
// in_stall is high from capture until the commit of that beat
// reset puts every port in idle, relays open, pulse length two ticks

module evse_port_state_controller_core
    import evse_psc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire in_beat_t   in_data,
    output logic            out_valid,
    input  wire logic       out_stall,
    output out_beat_t       out_data,
    input  wire logic       cfg_we,
    input  wire logic [7:0] cfg_wdata
);

    dp_cmd_t cmd;

    evse_psc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    evse_psc_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cmd       (cmd),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire
